// File: sv/tsmi_pkg.sv
// Shared types and constants for the timed servo motion interpolator.
// No dependencies.
package tsmi_pkg;
   localparam int unsigned NUM_BOARDS = 2;
   localparam int unsigned CHANNELS_PER_BOARD = 16;
   localparam int unsigned TOTAL_CH = NUM_BOARDS * CHANNELS_PER_BOARD;
   localparam int unsigned CH_W = $clog2(TOTAL_CH);
   localparam logic [16:0] HOLD_MS = 17'd500;
   localparam logic [7:0] FULL_ANGLE = 8'd180;

   localparam logic [1:0] REQ_MOVE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_LIMITS = 2'd2;

   localparam logic [1:0] ACT_PULSE = 2'd0;
   localparam logic [1:0] ACT_DISABLE = 2'd1;
   localparam logic [1:0] ACT_MARKER = 2'd2;

   localparam logic [1:0] REG_TRAVEL = 2'd0;

   // classified request passed from front to back
   typedef struct packed {
      logic [1:0] kind;
      logic [CH_W-1:0] idx;
      logic [7:0] target;
      logic [15:0] move_time;
      logic [11:0] lim_min;
      logic [11:0] lim_max;
   } cmd_type;

   typedef struct packed {
      logic out_board;
      logic [3:0] out_channel;
      logic [11:0] pulse_width;
      logic [1:0] action;
      logic last;
   } rsp_type;
endpackage

// File: sv/tsmi_if.sv
// Valid/ready channel interfaces for request and response.
// No dependencies.
interface tsmi_req_if;
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic board_sel;
   logic [3:0] channel_sel;
   logic [7:0] target_pos;
   logic [15:0] move_time;
   logic [11:0] limit_min;
   logic [11:0] limit_max;
   modport source(output valid, req_type, board_sel, channel_sel, target_pos,
                  move_time, limit_min, limit_max, input ready);
   modport sink(input valid, req_type, board_sel, channel_sel, target_pos,
                move_time, limit_min, limit_max, output ready);
endinterface

interface tsmi_rsp_if;
   logic valid;
   logic ready;
   logic out_board;
   logic [3:0] out_channel;
   logic [11:0] pulse_width;
   logic [1:0] action;
   logic last;
   modport source(output valid, out_board, out_channel, pulse_width, action, last,
                  input ready);
   modport sink(input valid, out_board, out_channel, pulse_width, action, last,
                output ready);
endinterface

// File: sv/tsmi_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tsmi_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: sv/tsmi_front.sv
// Front end: accepts requests, drops invalid ones, queues commands.
// Depends on tsmi_pkg and tsmi_if.
module tsmi_front (
   input  logic clock,
   input  logic reset,
   tsmi_req_if.sink req,
   output tsmi_pkg::cmd_type cmd,
   output logic cmd_valid,
   input  logic cmd_pop
);
   import tsmi_pkg::*;

   // two-entry queue
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, keep;
   cmd_type c;

   assign req.ready = (cnt_ff != 2'd2);
   assign keep = (req.req_type == REQ_MOVE) || (req.req_type == REQ_TICK)
               || (req.req_type == REQ_LIMITS);
   assign push = req.valid && req.ready && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      c.kind = req.req_type;
      c.idx = CH_W'({req.board_sel, req.channel_sel});
      c.target = (req.target_pos > FULL_ANGLE) ? FULL_ANGLE : req.target_pos;
      c.move_time = req.move_time;
      c.lim_min = req.limit_min;
      c.lim_max = req.limit_max;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      if (cmd_pop) begin
         q_ff[0] <= (cnt_ff == 2'd2) ? q_ff[1] : c;
         if (push) q_ff[1] <= c;
      end else if (push) begin
         if (cnt_ff == 2'd0) q_ff[0] <= c;
         else q_ff[1] <= c;
      end
   end
endmodule

// File: sv/tsmi_back.sv
// Back end: channel table, sweep sequencer with serial divider, result register.
// Depends on tsmi_pkg and tsmi_ram.
module tsmi_back (
   input  logic clock,
   input  logic reset,
   input  tsmi_pkg::cmd_type cmd,
   input  logic cmd_valid,
   output logic cmd_pop,
   input  logic [7:0] travel,
   output tsmi_pkg::rsp_type rsp,
   output logic rsp_valid,
   input  logic rsp_ready
);
   import tsmi_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MOVE = 4'd2,
      S_CHK = 4'd3, S_MUL = 4'd4, S_DIV1 = 4'd5, S_ADD1 = 4'd6,
      S_MUL2 = 4'd7, S_DIV2 = 4'd8, S_EMIT = 4'd9, S_WAIT = 4'd10,
      S_MARK = 4'd11, S_SEL = 4'd12, S_SWRD = 4'd13, S_CLR = 4'd14;

   // ceil(2^28 / 180): exact floor division by 180 for dividends below 2^20
   localparam logic [20:0] RECIP_180 = 21'd1491309;

   logic [3:0] st_ff, st_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [31:0] now_ff, now_in;
   logic [CH_W:0] clr_ff, clr_in;
   logic [1:0] kind_ff;
   cmd_type cmd_lat;

   // channel record in RAM: start,end,cur,dur,stamp,dis,lo,hi
   localparam int unsigned RW = 8 + 8 + 8 + 16 + 32 + 1 + 12 + 12;
   typedef struct packed {
      logic [7:0] s_ang;
      logic [7:0] e_ang;
      logic [7:0] c_ang;
      logic [15:0] dur;
      logic [31:0] stamp;
      logic dis;
      logic [11:0] lo;
      logic [11:0] hi;
   } rec_type;

   rec_type rd, wd, rec_ff, rec_in;
   logic we;
   logic [CH_W-1:0] wa, ra;

   tsmi_ram #(.WIDTH(RW), .DEPTH(TOTAL_CH)) u_tab (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   // arithmetic registers
   logic signed [24:0] prod_ff, prod_in;
   logic [23:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [23:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   logic [4:0] bit_ff, bit_in;
   logic [31:0] el_ff, el_in;
   logic [7:0] pos_ff, pos_in;
   rsp_type r_ff, r_in;
   rsp_type hold_ff, hold_in;
   logic rv_ff, rv_in;

   logic [8:0] gap;
   logic [16:0] minimum;
   logic [31:0] elapsed;
   logic [24:0] rtrial;
   logic signed [12:0] span;
   logic signed [13:0] addv;
   logic [40:0] recip;

   assign rsp = r_ff;
   assign rsp_valid = rv_ff;

   always_comb begin
      st_in = st_ff; ch_in = ch_ff; now_in = now_ff; clr_in = clr_ff;
      rec_in = rec_ff; prod_in = prod_ff; rem_in = rem_ff; quo_in = quo_ff;
      dvs_in = dvs_ff; neg_in = neg_ff; bit_in = bit_ff; el_in = el_ff;
      pos_in = pos_ff; r_in = r_ff; rv_in = rv_ff; hold_in = hold_ff;
      we = 1'b0; wa = ch_ff; wd = rec_ff; ra = ch_ff; cmd_pop = 1'b0;
      gap = '0; minimum = '0; elapsed = now_ff - rec_ff.stamp;
      rtrial = '0; span = '0; addv = '0; recip = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         // clear table after reset, one entry per cycle
         S_CLR: begin
            we = 1'b1; wa = clr_ff[CH_W-1:0]; wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (CH_W+1)'(TOTAL_CH - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == REQ_TICK) begin
                  now_in = now_ff + 32'd1; ch_in = '0; st_in = S_SWRD;
               end else begin
                  ch_in = cmd.idx; st_in = S_RD;
               end
            end
         end
         S_RD: begin
            st_in = S_MOVE;
         end
         // move or limits update on addressed channel
         S_MOVE: begin
            wd = rd;
            if (kind_ff == REQ_MOVE) begin
               gap = (rd.c_ang > cmd_lat.target) ? 9'(rd.c_ang - cmd_lat.target)
                                                 : 9'(cmd_lat.target - rd.c_ang);
               minimum = 17'(gap * travel);
               wd.s_ang = rd.c_ang;
               wd.e_ang = cmd_lat.target;
               wd.dur = (minimum > 17'(cmd_lat.move_time)) ? minimum[15:0]
                                                            : cmd_lat.move_time;
               wd.stamp = now_ff;
               wd.dis = 1'b0;
            end else begin
               wd.lo = cmd_lat.lim_min; wd.hi = cmd_lat.lim_max;
            end
            we = 1'b1; st_in = S_IDLE;
         end
         S_SWRD: begin
            st_in = S_SEL;
         end
         S_SEL: begin
            rec_in = rd; st_in = S_CHK;
         end
         // classify channel in sweep
         S_CHK: begin
            if (rec_ff.c_ang != rec_ff.e_ang) begin
               if (rec_ff.dur == 16'd0) begin
                  pos_in = rec_ff.e_ang; st_in = S_MUL2;
               end else begin
                  el_in = (elapsed > 32'(rec_ff.dur)) ? 32'(rec_ff.dur) : elapsed;
                  st_in = S_MUL;
               end
            end else if ({15'd0, elapsed} > 47'(rec_ff.dur) + 47'(HOLD_MS)
                         && !rec_ff.dis) begin
               rec_in.dis = 1'b1;
               hold_in = '{out_board: ch_ff[CH_W-1], out_channel: 4'(ch_ff),
                           pulse_width: '0, action: ACT_DISABLE, last: 1'b0};
               st_in = S_EMIT;
            end else st_in = S_WAIT;
         end
         S_MUL: begin
            prod_in = 25'($signed({1'b0, rec_ff.e_ang}) - $signed({1'b0, rec_ff.s_ang}))
                      * $signed({1'b0, el_ff[15:0]});
            st_in = S_DIV1; bit_in = '0; rem_in = '0; quo_in = '0;
            dvs_in = 24'(rec_ff.dur);
         end
         // restoring divide of |prod| by dvs, one bit per cycle
         S_DIV1: begin
            if (bit_ff == 5'd0) begin
               neg_in = prod_ff[24];
               el_in = prod_ff[24] ? 32'(-prod_ff) : 32'(prod_ff);
               rem_in = '0; quo_in = '0; bit_in = 5'd1;
            end else begin
               rtrial = {rem_ff, el_ff[23]};
               el_in = {el_ff[30:0], 1'b0};
               if (rtrial >= 25'(dvs_ff)) begin
                  rem_in = 24'(rtrial - 25'(dvs_ff)); quo_in = {quo_ff[22:0], 1'b1};
               end else begin
                  rem_in = rtrial[23:0]; quo_in = {quo_ff[22:0], 1'b0};
               end
               bit_in = bit_ff + 5'd1;
               if (bit_ff == 5'd24) st_in = S_ADD1;
            end
         end
         S_ADD1: begin
            addv = 14'({1'b0, rec_ff.s_ang}) + (neg_ff ? -14'(quo_ff[8:0])
                                                       : 14'(quo_ff[8:0]));
            if (addv[13]) pos_in = '0;
            else if (addv > 14'(FULL_ANGLE)) pos_in = FULL_ANGLE;
            else pos_in = addv[7:0];
            st_in = S_MUL2;
         end
         S_MUL2: begin
            rec_in.c_ang = pos_ff;
            span = $signed({1'b0, rec_ff.hi}) - $signed({1'b0, rec_ff.lo});
            prod_in = 25'($signed({1'b0, pos_ff}) * span);
            bit_in = '0; st_in = S_DIV2;
         end
         // pulse scale: magnitude first, then divide by 180 via reciprocal
         S_DIV2: begin
            if (bit_ff == 5'd0) begin
               neg_in = prod_ff[24];
               el_in = prod_ff[24] ? 32'(-prod_ff) : 32'(prod_ff);
               bit_in = 5'd1;
            end else begin
               recip = 41'(el_ff[19:0]) * 41'(RECIP_180);
               quo_in = 24'(recip[40:28]);
               addv = neg_ff ? -14'(quo_in[12:0]) : 14'(quo_in[12:0]);
               hold_in = '{out_board: ch_ff[CH_W-1], out_channel: 4'(ch_ff),
                           pulse_width: 12'(addv + 14'(rec_ff.lo)),
                           action: ACT_PULSE, last: 1'b0};
               st_in = S_EMIT;
            end
         end
         // hand out result, write record back
         S_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               r_in = hold_ff;
               rv_in = 1'b1; we = 1'b1; wd = rec_ff; st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (ch_ff == CH_W'(TOTAL_CH - 1)) st_in = S_MARK;
            else begin
               ch_in = ch_ff + 1'b1; ra = ch_in; st_in = S_SWRD;
            end
         end
         S_MARK: begin
            if (!rv_ff || rsp_ready) begin
               r_in = '{out_board: 1'b0, out_channel: 4'd0, pulse_width: '0,
                        action: ACT_MARKER, last: 1'b1};
               rv_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; now_ff <= '0; rv_ff <= 1'b0; ch_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; now_ff <= now_in; rv_ff <= rv_in;
         ch_ff <= ch_in;
      end
      if (cmd_pop) begin
         cmd_lat <= cmd; kind_ff <= cmd.kind;
      end
      rec_ff <= rec_in; prod_ff <= prod_in; rem_ff <= rem_in; quo_ff <= quo_in;
      dvs_ff <= dvs_in; neg_ff <= neg_in; bit_ff <= bit_in; el_ff <= el_in;
      pos_ff <= pos_in; r_ff <= r_in; hold_ff <= hold_in;
   end
endmodule

// File: sv/timed_servo_motion_interpolator_core.sv
// Timed servo motion interpolator, top level.
// Depends on tsmi_pkg, tsmi_if, tsmi_front, tsmi_back.
//
// Requests arrive on req (valid/ready): move, limits load or 1 ms tick.
// Moves and limits update one channel table entry and return no response.
// A tick sweeps all 32 channels and returns one response per moving or
// newly idle channel, then a marker response with last set. When a
// position is interpolated, the sweep runs a 24-step serial divide by the
// duration, then a reciprocal multiply for the pulse scale.
// A two-entry request queue lets the front accept while the back works.
// Responses leave through one output register; when the receiver stalls
// the sweep waits on that register. After reset the channel table RAM is
// cleared entry by entry; requests queue meanwhile. travel_ms_per_degree
// lies at csr address 0 and resets to 2.
module timed_servo_motion_interpolator_core (
   input  logic clock,
   input  logic reset,
   tsmi_req_if.sink req,
   tsmi_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import tsmi_pkg::*;

   cmd_type cmd;
   rsp_type r;
   logic cmd_valid, cmd_pop;
   logic [7:0] travel_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_TRAVEL) ? {24'd0, travel_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) travel_ff <= 8'd2;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_TRAVEL)
         travel_ff <= csr_pwdata[7:0];
   end

   tsmi_front u_front (.clock(clock), .reset(reset), .req(req), .cmd(cmd),
                       .cmd_valid(cmd_valid), .cmd_pop(cmd_pop));

   tsmi_back u_back (.clock(clock), .reset(reset), .cmd(cmd),
                     .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .travel(travel_ff),
                     .rsp(r), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready));

   assign rsp.out_board = r.out_board;
   assign rsp.out_channel = r.out_channel;
   assign rsp.pulse_width = r.pulse_width;
   assign rsp.action = r.action;
   assign rsp.last = r.last;
endmodule

// File: sv/tsmi_checker.sv
// Port-level checks for the interpolator core, bound to the top level.
// Depends on tsmi_pkg.
module tsmi_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_action,
   input logic rsp_last,
   input logic [11:0] rsp_pulse_width
);
   import tsmi_pkg::*;

   // last is set exactly on the sweep marker
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_action == ACT_MARKER))) else $error("last");
   // disable carries zero pulse
   a_dis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_DISABLE |-> rsp_pulse_width == 12'd0)
      else $error("disable pulse");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
      else $error("hold");
   // nothing out right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("reset");
endmodule

bind timed_servo_motion_interpolator_core tsmi_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_action(rsp.action), .rsp_last(rsp.last),
   .rsp_pulse_width(rsp.pulse_width));
